// File: rtl/qpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_pkg
// Shared constants, types and the quadrature step tables for the position
// counter.
// ----------------------------------------------------------------------------
package qpc_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int FIELD_W        = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int SUM_W          = ((POSITION_WIDTH > FIELD_W) ? POSITION_WIDTH : FIELD_W) + 2;
	localparam int IN_DATA_W      = 24;
	localparam int OUT_DATA_W     = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 2'd3;

	localparam logic [FIELD_W-1:0] MAX_POS_RST = 16'd64;
	localparam logic [FIELD_W-1:0] MIN_POS_RST = 16'd0;
	localparam logic [FIELD_W-1:0] STEP_RST    = 16'd1;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_CCW = 1'b1;

	// line state: bit 0 is channel A, bit 1 is channel B
	localparam logic [1:0] LINES_00 = 2'b00;
	localparam logic [1:0] LINES_01 = 2'b01;
	localparam logic [1:0] LINES_11 = 2'b11;
	localparam logic [1:0] LINES_10 = 2'b10;

	typedef struct packed {
		logic [FIELD_W-1:0] max_pos;
		logic [FIELD_W-1:0] min_pos;
		logic [FIELD_W-1:0] step;
		logic               wrap;
	} qpc_cfg_t;

	typedef struct packed {
		logic [1:0]                last_lines;
		logic                      last_dir;
		logic [POSITION_WIDTH-1:0] pos;
	} qpc_state_t;

	typedef struct packed {
		logic               func;
		logic [1:0]         lines;
		logic [FIELD_W-1:0] load_value;
	} qpc_item_t;

	function automatic logic [1:0] cw_next(input logic [1:0] lines);
		logic [1:0] r;
		case (lines)
			LINES_00: r = LINES_01;
			LINES_01: r = LINES_11;
			LINES_11: r = LINES_10;
			default:  r = LINES_00;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] ccw_next(input logic [1:0] lines);
		logic [1:0] r;
		case (lines)
			LINES_00: r = LINES_10;
			LINES_01: r = LINES_00;
			LINES_11: r = LINES_01;
			default:  r = LINES_11;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/qpc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpc_step
// Next-state logic for one request: direction decode, add or subtract the
// step, bound compare with wrap or clamp, and position load.
// ----------------------------------------------------------------------------
module qpc_step
	import qpc_pkg::*;
(
	input  qpc_cfg_t   cfg,
	input  qpc_state_t st,
	input  qpc_item_t  item,
	output qpc_state_t nxt,
	output logic       moved
);

	logic                    changed;
	logic                    dir_new;
	logic signed [SUM_W-1:0] pos_w;
	logic signed [SUM_W-1:0] step_w;
	logic signed [SUM_W-1:0] max_w;
	logic signed [SUM_W-1:0] min_w;
	logic signed [SUM_W-1:0] load_w;
	logic signed [SUM_W-1:0] sum_up;
	logic signed [SUM_W-1:0] sum_dn;
	logic signed [SUM_W-1:0] sum_sel;

	assign pos_w  = {{(SUM_W-POSITION_WIDTH){st.pos[POSITION_WIDTH-1]}}, st.pos};
	assign step_w = {{(SUM_W-FIELD_W){cfg.step[FIELD_W-1]}}, cfg.step};
	assign max_w  = {{(SUM_W-FIELD_W){cfg.max_pos[FIELD_W-1]}}, cfg.max_pos};
	assign min_w  = {{(SUM_W-FIELD_W){cfg.min_pos[FIELD_W-1]}}, cfg.min_pos};
	assign load_w = {{(SUM_W-FIELD_W){item.load_value[FIELD_W-1]}}, item.load_value};

	assign sum_up = pos_w + step_w;
	assign sum_dn = pos_w - step_w;

	assign changed = (item.lines != st.last_lines);

	always_comb begin
		if (item.lines == cw_next(st.last_lines)) begin
			dir_new = DIR_CW;
		end else if (item.lines == ccw_next(st.last_lines)) begin
			dir_new = DIR_CCW;
		end else begin
			dir_new = st.last_dir;
		end
	end

	always_comb begin
		if (dir_new == DIR_CW) begin
			sum_sel = (sum_up > max_w) ? (cfg.wrap ? min_w : max_w) : sum_up;
		end else begin
			sum_sel = (sum_dn < min_w) ? (cfg.wrap ? max_w : min_w) : sum_dn;
		end
	end

	always_comb begin
		nxt   = st;
		moved = 1'b0;
		if (item.func == FUNC_LOAD) begin
			nxt.pos = load_w[POSITION_WIDTH-1:0];
		end else if (changed) begin
			nxt.pos        = sum_sel[POSITION_WIDTH-1:0];
			nxt.last_dir   = dir_new;
			nxt.last_lines = item.lines;
			moved          = 1'b1;
		end
	end

endmodule

// File: rtl/quadrature_position_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_position_counter_core
// x4 quadrature decoder with a signed, bounded position counter.
// ----------------------------------------------------------------------------
// Each request is either a sample of encoder lines A and B or a position
// load, and gives exactly one result: position, last direction and a moved
// flag. The request is registered; decode, add and bound compare then run
// combinationally into the result register, loaded once it is empty or being
// taken. The position register closes its update loop combinationally, which
// lets the block take one request per clock unless m_tready holds the output.
// s_tready falls only while both the request and the result register are full
// and m_tready is low. The user must write configuration only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module quadrature_position_counter_core
	import qpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // line_a, line_b, load_value[15:0], zero pad
	input  logic                  s_tuser,   // func

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // position[15:0], direction, moved, zero pad
);

	qpc_cfg_t   cfg_q;
	qpc_state_t st_q;
	qpc_state_t st_nxt;
	qpc_item_t  item_s1;
	logic       valid_s1;
	logic       moved_nxt;
	logic       adv;

	logic                    out_valid_q;
	logic [FIELD_W-1:0]      out_pos_q;
	logic                    out_dir_q;
	logic                    out_moved_q;
	logic signed [SUM_W-1:0] pos_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pos <= MAX_POS_RST;
			cfg_q.min_pos <= MIN_POS_RST;
			cfg_q.step    <= STEP_RST;
			cfg_q.wrap    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_POS: cfg_q.max_pos <= cfg_data;
				CFG_MIN_POS: cfg_q.min_pos <= cfg_data;
				CFG_STEP:    cfg_q.step    <= cfg_data;
				CFG_WRAP:    cfg_q.wrap    <= cfg_data[0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func       <= s_tuser;
			item_s1.lines      <= s_tdata[1:0];
			item_s1.load_value <= s_tdata[FIELD_W+1:2];
		end
	end

	qpc_step u_step (
		.cfg   (cfg_q),
		.st    (st_q),
		.item  (item_s1),
		.nxt   (st_nxt),
		.moved (moved_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	assign pos_ext = {{(SUM_W-POSITION_WIDTH){st_nxt.pos[POSITION_WIDTH-1]}}, st_nxt.pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pos_q   <= pos_ext[FIELD_W-1:0];
			out_dir_q   <= st_nxt.last_dir;
			out_moved_q <= moved_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-FIELD_W-2){1'b0}}, out_moved_q, out_dir_q, out_pos_q};

`ifndef NO_ASSERTIONS
	a_load_not_moved: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.func == FUNC_LOAD) |=> !out_moved_q)
		else $error("load request reported as a move");

	a_idle_sample_holds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.func == FUNC_SAMPLE) && (item_s1.lines == st_q.last_lines)
		|=> (st_q == $past(st_q)) && !out_moved_q)
		else $error("unchanged lines altered the counter state");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("pending request lost before update");
`endif

endmodule

// File: tb/tb_quadrature_position_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_position_counter_core
// Self-checking bench for the x4 quadrature position counter.
// ----------------------------------------------------------------------------
// A short table of line samples, loads and register writes comes first:
// Gray steps both ways, an illegal jump, unchanged lines, loads at the
// extremes, wrap and clamp at both bounds, negative and extreme step sizes,
// crossed bounds and positions past the 16-bit range. Random segments follow,
// each with its own register setting, mostly legal Gray sequences with some
// loads, repeats and illegal jumps. Each result is checked against its table
// row or a bench position tracker, under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_quadrature_position_counter_core
	import qpc_pkg::*;
;

	localparam int STALL_LIMIT = 2000;
	localparam int SEGMENTS    = 19;
	localparam int SEG_ITEMS   = 100;

	typedef struct {
		logic [15:0] position;
		logic        direction;
		logic        moved;
	} reading_t;

	typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic           func;
		logic [1:0]     lines;
		logic [15:0]    value;
		logic [CFG_IDX_W-1:0] index;
		bit             typed;
		logic [15:0]    position;
		logic           direction;
		logic           moved;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// bench copy of the block's registers and state
	logic signed [15:0] upper_bound;
	logic signed [15:0] lower_bound;
	logic signed [15:0] step_amount;
	logic               wrap_on;
	logic [1:0]         held_lines;
	logic               held_dir;
	logic signed [15:0] count;

	reading_t pending_readings[$];
	int       mismatches;
	int       stall_cycles;
	int       tx_idle_pct;
	int       rx_idle_pct;

	quadrature_position_counter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [1:0] gray_cw(input logic [1:0] lines);
		case (lines)
			LINES_00: return LINES_01;
			LINES_01: return LINES_11;
			LINES_11: return LINES_10;
			default:  return LINES_00;
		endcase
	endfunction

	function automatic logic [1:0] gray_ccw(input logic [1:0] lines);
		case (lines)
			LINES_00: return LINES_10;
			LINES_10: return LINES_11;
			LINES_11: return LINES_01;
			default:  return LINES_00;
		endcase
	endfunction

	function automatic reading_t advance_counter(input logic f, input logic [1:0] lines,
			input logic [15:0] load);
		reading_t r;
		longint   sum;
		r.moved = 1'b0;
		if (f == FUNC_LOAD) begin
			count = load;
		end else if (lines != held_lines) begin
			if (lines == gray_cw(held_lines))
				held_dir = DIR_CW;
			else if (lines == gray_ccw(held_lines))
				held_dir = DIR_CCW;
			if (held_dir == DIR_CW) begin
				sum = longint'(count) + longint'(step_amount);
				if (sum > longint'(upper_bound))
					sum = wrap_on ? longint'(lower_bound) : longint'(upper_bound);
			end else begin
				sum = longint'(count) - longint'(step_amount);
				if (sum < longint'(lower_bound))
					sum = wrap_on ? longint'(upper_bound) : longint'(lower_bound);
			end
			count = sum[15:0];
			held_lines = lines;
			r.moved = 1'b1;
		end
		r.position = count;
		r.direction = held_dir;
		return r;
	endfunction

	task automatic send_request(input logic f, input logic [1:0] lines, input logic [15:0] load,
			input bit typed, input reading_t typed_reading);
		reading_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {{(IN_DATA_W-18){1'b0}}, load, lines};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = advance_counter(f, lines, load);
		pending_readings.push_back(typed ? typed_reading : r);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_MAX_POS: upper_bound = value;
			CFG_MIN_POS: lower_bound = value;
			CFG_STEP:    step_amount = value;
			default:     wrap_on = value[0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// directed table
	row_t rows[] = '{
		'{ROW_REQ, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_MAX_POS, 1, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_01, 16'hFFFF, CFG_MAX_POS, 1, 16'h0001, DIR_CW,  1'b1},
		'{ROW_REQ, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_MAX_POS, 1, 16'h0000, DIR_CCW, 1'b1},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 1, 16'h0000, DIR_CCW, 1'b1},
		'{ROW_REQ, FUNC_SAMPLE, LINES_01, 16'h0000, CFG_MAX_POS, 1, 16'h0000, DIR_CCW, 1'b1},
		'{ROW_REQ, FUNC_LOAD,   LINES_11, 16'h7FFF, CFG_MAX_POS, 1, 16'h7FFF, DIR_CCW, 1'b0},
		'{ROW_REQ, FUNC_LOAD,   LINES_00, 16'h8000, CFG_MAX_POS, 1, 16'h8000, DIR_CCW, 1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_11, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_LOAD,   LINES_10, 16'h0040, CFG_MAX_POS, 1, 16'h0040, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 1, 16'h0040, DIR_CW,  1'b1},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 1, 16'h0040, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_11, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h0001, CFG_WRAP,    0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_LOAD,   LINES_00, 16'h0040, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_11, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h7FFF, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h8000, CFG_MIN_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h8000, CFG_STEP,    0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_LOAD,   LINES_11, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_10, 16'h0000, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h7FFF, CFG_STEP,    0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_WRAP,    0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_LOAD,   LINES_01, 16'h7FFF, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_MAX_POS, 1, 16'h7FFF, DIR_CW,  1'b1},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'hFF9C, CFG_MAX_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REG, FUNC_SAMPLE, LINES_00, 16'h0064, CFG_MIN_POS, 0, 16'h0000, DIR_CW,  1'b0},
		'{ROW_REQ, FUNC_SAMPLE, LINES_01, 16'h0000, CFG_MAX_POS, 1, 16'hFF9C, DIR_CW,  1'b1},
		'{ROW_REQ, FUNC_SAMPLE, LINES_00, 16'h0000, CFG_MAX_POS, 1, 16'h0064, DIR_CCW, 1'b1}
	};

	initial begin
		reading_t   typed_reading;
		logic [1:0] lines;
		logic [15:0] load;
		logic       f;
		int         roll;
		int         lo_i;
		int         hi_i;
		int         st_i;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_MAX_POS;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_SAMPLE;
		upper_bound = MAX_POS_RST;
		lower_bound = MIN_POS_RST;
		step_amount = STEP_RST;
		wrap_on     = 1'b0;
		held_lines  = LINES_00;
		held_dir    = DIR_CW;
		count       = '0;
		mismatches  = 0;
		tx_idle_pct = 6;
		rx_idle_pct = 64;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				drain();
				write_reg(rows[i].index, rows[i].value);
			end else begin
				typed_reading.position  = rows[i].position;
				typed_reading.direction = rows[i].direction;
				typed_reading.moved     = rows[i].moved;
				send_request(rows[i].func, rows[i].lines, rows[i].value, rows[i].typed,
					typed_reading);
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			tx_idle_pct = (seg < 6) ? 6 : (seg < 12) ? 64 : 0;
			rx_idle_pct = (seg < 6) ? 64 : (seg < 12) ? 6 : 0;
			drain();
			case ($urandom_range(2))
				0: begin
					lo_i = int'($urandom_range(40)) - 20;
					hi_i = lo_i + int'($urandom_range(60, 1));
					st_i = int'($urandom_range(4, 1));
					if ($urandom_range(7) == 0)
						st_i = -st_i;
				end
				1: begin
					lo_i = -32768;
					hi_i = 32767;
					st_i = int'($urandom);
				end
				default: begin
					lo_i = int'($urandom);
					hi_i = int'($urandom);
					st_i = int'($urandom);
				end
			endcase
			write_reg(CFG_MAX_POS, hi_i[15:0]);
			write_reg(CFG_MIN_POS, lo_i[15:0]);
			write_reg(CFG_STEP, st_i[15:0]);
			write_reg(CFG_WRAP, {15'b0, 1'($urandom_range(1))});
			for (int n = 0; n < SEG_ITEMS; n++) begin
				roll = $urandom_range(99);
				f    = FUNC_SAMPLE;
				load = 16'($urandom);
				if (roll < 10) begin
					f     = FUNC_LOAD;
					lines = 2'($urandom);
					if ($urandom_range(3) == 0) begin
						case ($urandom_range(3))
							0:       load = 16'h7FFF;
							1:       load = 16'h8000;
							2:       load = 16'h0000;
							default: load = 16'hFFFF;
						endcase
					end else if ($urandom_range(1) == 1) begin
						lo_i = int'(lower_bound) + int'($urandom_range(70)) - 5;
						load = lo_i[15:0];
					end
				end else if (roll < 70)
					lines = gray_cw(held_lines);
				else if (roll < 85)
					lines = gray_ccw(held_lines);
				else if (roll < 92)
					lines = held_lines;
				else
					lines = ~held_lines;
				send_request(f, lines, load, 1'b0, typed_reading);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial m_tready <= 1'b0;

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: tdata %h", m_tdata);
			end else begin
				want = pending_readings.pop_front();
				if (m_tdata[15:0] !== want.position || m_tdata[16] !== want.direction ||
						m_tdata[17] !== want.moved) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: position %h dir %b moved %b, got %h %b %b",
							want.position, want.direction, want.moved,
							m_tdata[15:0], m_tdata[16], m_tdata[17]);
				end
			end
		end
	end

	// watchdog on request and result traffic
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial stall_cycles = 0;

endmodule

// File: files.f
rtl/qpc_pkg.sv
rtl/qpc_step.sv
rtl/quadrature_position_counter_core.sv
tb/tb_quadrature_position_counter_core.sv
